// ----- rtl/core/mexp_pkg.sv -----
// ----------------------------------------------------------------------------
// mexp_pkg: shared definitions for the modular exponentiation block
// Default operand widths and the sequencer state type.
// ----------------------------------------------------------------------------
package mexp_pkg;

   localparam int OPERAND_BITS_DEF  = 32;
   localparam int EXPONENT_BITS_DEF = 64;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_RED_GO,
      ST_RED_WAIT,
      ST_STEP,
      ST_MUL_WAIT,
      ST_SQR_WAIT,
      ST_DONE
   } mexp_state_type;

endpackage

// ----- rtl/core/mexp_modmul.sv -----
// ----------------------------------------------------------------------------
// mexp_modmul: bit-serial modular multiplier
// Computes serial * addend mod modulus, one serial bit per cycle, MSB first.
// ----------------------------------------------------------------------------
module mexp_modmul
   import mexp_pkg::*;
#(
   parameter int OPERAND_BITS = OPERAND_BITS_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic [OPERAND_BITS-1:0] addend,
   input  logic [OPERAND_BITS-1:0] serial,
   input  logic [OPERAND_BITS-1:0] modulus,
   output logic                    done,
   output logic [OPERAND_BITS-1:0] product
);

   localparam int CW = $clog2(OPERAND_BITS);

   logic                    run_ff, run_in;
   logic                    done_ff, done_in;
   logic [CW-1:0]           cnt_ff, cnt_in;
   logic [OPERAND_BITS-1:0] ser_ff, ser_in;
   logic [OPERAND_BITS-1:0] add_ff, add_in;
   logic [OPERAND_BITS-1:0] r_ff, r_in;

   logic [OPERAND_BITS:0]   mod_ext;
   logic [OPERAND_BITS:0]   dbl;
   logic [OPERAND_BITS:0]   red1;
   logic [OPERAND_BITS:0]   sum;
   logic [OPERAND_BITS:0]   red2;

   // Each step doubles the partial result, reduces it, adds the addend when
   // the current serial bit is set and reduces again. The addend never
   // exceeds the modulus, so one subtraction per reduction is enough.
   always_comb begin
      mod_ext = {1'b0, modulus};
      dbl     = {r_ff, 1'b0};
      red1    = (dbl >= mod_ext) ? (dbl - mod_ext) : dbl;
      sum     = ser_ff[OPERAND_BITS-1] ? (red1 + {1'b0, add_ff}) : red1;
      red2    = (sum >= mod_ext) ? (sum - mod_ext) : sum;
   end

   always_comb begin
      run_in  = run_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      ser_in  = ser_ff;
      add_in  = add_ff;
      r_in    = r_ff;
      if (run_ff) begin
         r_in   = red2[OPERAND_BITS-1:0];
         ser_in = {ser_ff[OPERAND_BITS-2:0], 1'b0};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end
      end else if (start) begin
         run_in = 1'b1;
         cnt_in = CW'(OPERAND_BITS - 1);
         ser_in = serial;
         add_in = addend;
         r_in   = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      cnt_ff <= cnt_in;
      ser_ff <= ser_in;
      add_ff <= add_in;
      r_ff   <= r_in;
   end

   assign done    = done_ff;
   assign product = r_ff;

endmodule

// ----- rtl/core/modular_exponentiation_top.sv -----
// ----------------------------------------------------------------------------
// modular_exponentiation_top: base ^ exponent mod modulus
// Right-to-left square-and-multiply on one shared bit-serial multiplier.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Ports                                   Handshake
// request   in         req_base, req_exponent, req_modulus     start & !busy
// response  out        rsp_result, rsp_mod_error               rsp_valid, 1 cycle
//
// A request with a zero modulus is answered in the cycle right after it is
// accepted, with busy high for that one cycle. Any other request first
// reduces the base by multiplying it by one. Each exponent bit up to the
// highest set one then costs a square, plus a multiply for a set bit, and
// the states ST_STEP and ST_DONE finish the request.
// The single modular multiplier retires one multiplier bit per cycle and
// dominates the run time. Reset is synchronous and returns the block to
// idle; the receiver cannot stall, so the response is shown for exactly
// one cycle.
//
module modular_exponentiation_top
   import mexp_pkg::*;
#(
   parameter int OPERAND_BITS  = OPERAND_BITS_DEF,
   parameter int EXPONENT_BITS = EXPONENT_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   output logic                     busy,
   input  logic [OPERAND_BITS-1:0]  req_base,
   input  logic [EXPONENT_BITS-1:0] req_exponent,
   input  logic [OPERAND_BITS-1:0]  req_modulus,
   output logic                     rsp_valid,
   output logic [OPERAND_BITS-1:0]  rsp_result,
   output logic                     rsp_mod_error
);

   mexp_state_type state_ff, state_in;

   // Request operands and the two running values of the algorithm: the
   // accumulated result and the current power of the base.
   logic [OPERAND_BITS-1:0]  base_ff, base_in;
   logic [EXPONENT_BITS-1:0] exp_ff, exp_in;
   logic [OPERAND_BITS-1:0]  mod_ff, mod_in;
   logic [OPERAND_BITS-1:0]  acc_ff, acc_in;
   logic [OPERAND_BITS-1:0]  pw_ff, pw_in;
   logic                     err_ff, err_in;

   // Shared multiplier interface.
   logic                     mul_start;
   logic [OPERAND_BITS-1:0]  mul_addend;
   logic [OPERAND_BITS-1:0]  mul_serial;
   logic                     mul_done;
   logic [OPERAND_BITS-1:0]  mul_product;

   logic                     accept;

   assign accept = start && (state_ff == ST_IDLE);

   // Next-state logic. The exponent register shifts right after every
   // squaring, so the scan ends as soon as no set bit remains.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = (req_modulus == '0) ? ST_DONE : ST_RED_GO;
            end
         end
         ST_RED_GO:   state_in = ST_RED_WAIT;
         ST_RED_WAIT: begin
            if (mul_done) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            if (exp_ff == '0) begin
               state_in = ST_DONE;
            end else if (exp_ff[0]) begin
               state_in = ST_MUL_WAIT;
            end else begin
               state_in = ST_SQR_WAIT;
            end
         end
         ST_MUL_WAIT: begin
            if (mul_done) begin
               state_in = ST_SQR_WAIT;
            end
         end
         ST_SQR_WAIT: begin
            if (mul_done) begin
               state_in = ST_STEP;
            end
         end
         ST_DONE: state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // Output and datapath control. The multiplier always adds a value that
   // is already reduced (one, or the current power), while the serial
   // operand may be the raw base, the accumulator or the current power.
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      rsp_valid     = 1'b0;
      rsp_result    = acc_ff;
      rsp_mod_error = err_ff;
      mul_start     = 1'b0;
      mul_addend    = pw_ff;
      mul_serial    = pw_ff;
      base_in       = base_ff;
      exp_in        = exp_ff;
      mod_in        = mod_ff;
      acc_in        = acc_ff;
      pw_in         = pw_ff;
      err_in        = err_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               base_in = req_base;
               exp_in  = req_exponent;
               mod_in  = req_modulus;
               if (req_modulus == '0) begin
                  acc_in = '0;
                  err_in = 1'b1;
               end else begin
                  acc_in = OPERAND_BITS'(1);
                  err_in = 1'b0;
               end
            end
         end
         ST_RED_GO: begin
            // The base is reduced by multiplying it by one.
            mul_start  = 1'b1;
            mul_addend = OPERAND_BITS'(1);
            mul_serial = base_ff;
         end
         ST_RED_WAIT: begin
            if (mul_done) begin
               pw_in = mul_product;
            end
         end
         ST_STEP: begin
            if (exp_ff != '0) begin
               mul_start  = 1'b1;
               mul_serial = exp_ff[0] ? acc_ff : pw_ff;
            end
         end
         ST_MUL_WAIT: begin
            if (mul_done) begin
               acc_in    = mul_product;
               mul_start = 1'b1;
            end
         end
         ST_SQR_WAIT: begin
            if (mul_done) begin
               pw_in  = mul_product;
               exp_in = exp_ff >> 1;
            end
         end
         ST_DONE: begin
            rsp_valid = 1'b1;
         end
         default: begin
            rsp_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      base_ff <= base_in;
      exp_ff  <= exp_in;
      mod_ff  <= mod_in;
      acc_ff  <= acc_in;
      pw_ff   <= pw_in;
      err_ff  <= err_in;
   end

   mexp_modmul #(
      .OPERAND_BITS (OPERAND_BITS)
   ) u_modmul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .addend  (mul_addend),
      .serial  (mul_serial),
      .modulus (mod_ff),
      .done    (mul_done),
      .product (mul_product)
   );

endmodule
